### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Types and codes shared by the relocalization request qualifier.
// ----------------------------------------------------------------------------
package rrq_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_HOLD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LIMIT    = 3'd4;

  // Reset values of the configuration registers
  localparam logic signed [31:0] ENTER_THRESHOLD_RST = 32'sd65536;
  localparam logic signed [31:0] EXIT_THRESHOLD_RST  = 32'sd32768;
  localparam logic [15:0]        ENTER_HOLD_RST      = 16'd3;
  localparam logic [15:0]        EXIT_HOLD_RST       = 16'd5;
  localparam logic [15:0]        REJECT_LIMIT_RST    = 16'd10;

  // Reported count width and its ceiling
  localparam int unsigned REPORT_W = 16;
  localparam logic [REPORT_W-1:0] REPORT_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    RC_UNINIT          = 4'd0,
    RC_MISSING         = 4'd1,
    RC_MISSING_PENDING = 4'd2,
    RC_INVALID         = 4'd3,
    RC_REJECTS         = 4'd4,
    RC_OK              = 4'd5,
    RC_RECOVERING      = 4'd6,
    RC_HIGH            = 4'd7,
    RC_HIGH_PENDING    = 4'd8
  } rrq_reason_t;

  typedef struct packed {
    logic signed [31:0] enter_threshold;
    logic signed [31:0] exit_threshold;
    logic [15:0]        enter_hold;
    logic [15:0]        exit_hold;
    logic [15:0]        reject_limit;
  } rrq_cfg_t;

  typedef struct packed {
    logic               initialized;
    logic               sources_ready;
    logic               residual_finite;
    logic signed [31:0] residual;
    logic [15:0]        reject_streak;
  } rrq_item_t;

  typedef struct packed {
    logic                request;
    rrq_reason_t         reason_code;
    logic [REPORT_W-1:0] enter_count;
    logic [REPORT_W-1:0] exit_count;
    logic [REPORT_W-1:0] degraded_count;
  } rrq_result_t;

endpackage

### hdl/relocalization_request_qualifier_unit.sv
// ----------------------------------------------------------------------------
// relocalization_request_qualifier_unit
// Hysteresis detector with hold counts that qualifies relocalization requests.
//
//   channel  handshake           payload
//   -------  ------------------  -------------------------------------------
//   in       in_valid/in_stall   initialized, sources_ready, residual_finite,
//                                residual, reject_streak
//   out      out_valid/out_stall request, reason_code, enter_count,
//                                exit_count, degraded_count
//   cfg      cfg_we              cfg_index, cfg_data (write only)
//
// One word per clock sustained while the output is not stalled; each word
// passes the input register, then the result register.
// Reset (rst, synchronous) loads the register defaults, raises the request
// flag and clears the counters and both stage valids.
// A stall on the output holds the result word; the input stage keeps taking
// words until both stages are full, then in_stall rises.
// ----------------------------------------------------------------------------
module relocalization_request_qualifier_unit #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrq_pkg::CFG_DATA_W-1:0]  cfg_data,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            initialized,
  input  logic                            sources_ready,
  input  logic                            residual_finite,
  input  logic signed [31:0]              residual,
  input  logic [15:0]                     reject_streak,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            request,
  output logic [3:0]                      reason_code,
  output logic [15:0]                     enter_count,
  output logic [15:0]                     exit_count,
  output logic [15:0]                     degraded_count
);

  rrq_pkg::rrq_cfg_t    cfg;
  rrq_pkg::rrq_item_t   item;
  rrq_pkg::rrq_result_t result;
  rrq_pkg::rrq_result_t result_reg;
  logic                 item_valid;
  logic                 advance;
  logic                 in_take;

  rrq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Hand the held sample on when the result register is free or being taken
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.initialized     <= initialized;
      item.sources_ready   <= sources_ready;
      item.residual_finite <= residual_finite;
      item.residual        <= residual;
      item.reject_streak   <= reject_streak;
    end
  end

  rrq_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign request        = result_reg.request;
  assign reason_code    = result_reg.reason_code;
  assign enter_count    = result_reg.enter_count;
  assign exit_count     = result_reg.exit_count;
  assign degraded_count = result_reg.degraded_count;

endmodule

### hdl/rrq_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrq_cfg_regs
// Configuration register file: thresholds, hold counts and reject limit.
// ----------------------------------------------------------------------------
module rrq_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rrq_pkg::rrq_cfg_t               cfg
);

  // Load the addressed register; unknown indices are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_threshold <= rrq_pkg::ENTER_THRESHOLD_RST;
      cfg.exit_threshold  <= rrq_pkg::EXIT_THRESHOLD_RST;
      cfg.enter_hold      <= rrq_pkg::ENTER_HOLD_RST;
      cfg.exit_hold       <= rrq_pkg::EXIT_HOLD_RST;
      cfg.reject_limit    <= rrq_pkg::REJECT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrq_pkg::CFG_ENTER_THRESHOLD: cfg.enter_threshold <= $signed(cfg_data[31:0]);
        rrq_pkg::CFG_EXIT_THRESHOLD:  cfg.exit_threshold  <= $signed(cfg_data[31:0]);
        rrq_pkg::CFG_ENTER_HOLD:      cfg.enter_hold      <= cfg_data[15:0];
        rrq_pkg::CFG_EXIT_HOLD:       cfg.exit_hold       <= cfg_data[15:0];
        rrq_pkg::CFG_REJECT_LIMIT:    cfg.reject_limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/rrq_core.sv
// ----------------------------------------------------------------------------
// rrq_core
// Qualifier state (request flag, enter/exit/degraded counters) and the
// combinational update that turns one sample into one result word.
// ----------------------------------------------------------------------------
module rrq_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  rrq_pkg::rrq_cfg_t    cfg,
  input  rrq_pkg::rrq_item_t   item,
  output rrq_pkg::rrq_result_t result
);

  // Compare width covers both the counters and the 16-bit holds
  localparam int unsigned CMP_W =
    (COUNT_WIDTH > rrq_pkg::REPORT_W) ? COUNT_WIDTH : rrq_pkg::REPORT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   request_flag;
  logic [COUNT_WIDTH-1:0] enter_run;
  logic [COUNT_WIDTH-1:0] exit_run;
  logic [COUNT_WIDTH-1:0] degraded_run;

  logic                   request_flag_next;
  logic [COUNT_WIDTH-1:0] enter_run_next;
  logic [COUNT_WIDTH-1:0] exit_run_next;
  logic [COUNT_WIDTH-1:0] degraded_run_next;

  logic [COUNT_WIDTH-1:0] rep_enter;
  logic [COUNT_WIDTH-1:0] rep_exit;
  logic [COUNT_WIDTH-1:0] rep_degraded;
  rrq_pkg::rrq_reason_t   reason;

  logic [COUNT_WIDTH-1:0] enter_inc;
  logic [COUNT_WIDTH-1:0] exit_inc;
  logic [COUNT_WIDTH-1:0] degraded_inc;
  logic [COUNT_WIDTH-1:0] enter_hold_sat;
  logic [CMP_W-1:0]       enter_hold_ext;
  logic [CMP_W-1:0]       exit_hold_ext;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic logic [CMP_W-1:0] widen(input logic [COUNT_WIDTH-1:0] v);
    return CMP_W'(v);
  endfunction

  function automatic logic [rrq_pkg::REPORT_W-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return (w > CMP_W'(rrq_pkg::REPORT_MAX)) ? rrq_pkg::REPORT_MAX
                                             : w[rrq_pkg::REPORT_W-1:0];
  endfunction

  // Shared increments and hold loads
  assign enter_inc      = sat_inc(enter_run);
  assign exit_inc       = sat_inc(exit_run);
  assign degraded_inc   = sat_inc(degraded_run);
  assign enter_hold_ext = CMP_W'(cfg.enter_hold);
  assign exit_hold_ext  = CMP_W'(cfg.exit_hold);
  assign enter_hold_sat = (enter_hold_ext > widen(CNT_MAX)) ? CNT_MAX
                                                            : enter_hold_ext[COUNT_WIDTH-1:0];

  // Work out the next state and the reported fields for this sample
  always_comb begin
    request_flag_next = request_flag;
    enter_run_next    = enter_run;
    exit_run_next     = exit_run;
    degraded_run_next = degraded_run;
    rep_enter         = '0;
    rep_exit          = '0;
    rep_degraded      = '0;
    reason            = rrq_pkg::RC_OK;

    if (!item.initialized) begin
      request_flag_next = 1'b1;
      enter_run_next    = '0;
      exit_run_next     = '0;
      degraded_run_next = '0;
      reason            = rrq_pkg::RC_UNINIT;
    end else if (!item.sources_ready) begin
      degraded_run_next = degraded_inc;
      enter_run_next    = '0;
      exit_run_next     = '0;
      rep_degraded      = degraded_inc;
      if (widen(degraded_inc) >= enter_hold_ext) begin
        request_flag_next = 1'b1;
        reason            = rrq_pkg::RC_MISSING;
      end else begin
        reason = rrq_pkg::RC_MISSING_PENDING;
      end
    end else begin
      degraded_run_next = '0;
      if (!item.residual_finite) begin
        request_flag_next = 1'b1;
        enter_run_next    = '0;
        exit_run_next     = '0;
        reason            = rrq_pkg::RC_INVALID;
      end else if (item.reject_streak >= cfg.reject_limit) begin
        request_flag_next = 1'b1;
        enter_run_next    = enter_hold_sat;
        exit_run_next     = '0;
        rep_enter         = enter_hold_sat;
        reason            = rrq_pkg::RC_REJECTS;
      end else begin
        // Hysteresis: count towards clearing while on, towards raising while off
        if (request_flag) begin
          if (item.residual < cfg.exit_threshold) begin
            if (widen(exit_inc) >= exit_hold_ext) begin
              request_flag_next = 1'b0;
              enter_run_next    = '0;
              exit_run_next     = '0;
              reason            = rrq_pkg::RC_OK;
            end else begin
              exit_run_next = exit_inc;
              reason        = rrq_pkg::RC_RECOVERING;
            end
          end else begin
            exit_run_next = '0;
            reason        = rrq_pkg::RC_HIGH;
          end
        end else begin
          if (cfg.enter_threshold < item.residual) begin
            if (widen(enter_inc) >= enter_hold_ext) begin
              request_flag_next = 1'b1;
              enter_run_next    = enter_hold_sat;
              exit_run_next     = '0;
              reason            = rrq_pkg::RC_HIGH;
            end else begin
              enter_run_next = enter_inc;
              reason         = rrq_pkg::RC_HIGH_PENDING;
            end
          end else begin
            enter_run_next = '0;
            reason         = rrq_pkg::RC_OK;
          end
        end
        rep_enter = enter_run_next;
        rep_exit  = exit_run_next;
      end
    end
  end

  // Advance the state once per sample handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      request_flag <= 1'b1;
      enter_run    <= '0;
      exit_run     <= '0;
      degraded_run <= '0;
    end else if (step) begin
      request_flag <= request_flag_next;
      enter_run    <= enter_run_next;
      exit_run     <= exit_run_next;
      degraded_run <= degraded_run_next;
    end
  end

  // Clip counts to the reported width
  always_comb begin
    result.request        = request_flag_next;
    result.reason_code    = reason;
    result.enter_count    = clip(rep_enter);
    result.exit_count     = clip(rep_exit);
    result.degraded_count = clip(rep_degraded);
  end

endmodule

### hdl/rrq_checker.sv
// ----------------------------------------------------------------------------
// rrq_checker
// Port-level checks on the qualifier's result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        request,
  input logic [3:0]  reason_code,
  input logic [15:0] enter_count,
  input logic [15:0] exit_count,
  input logic [15:0] degraded_count
);

  // A stalled result word stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // Uninitialised estimator: request on, nothing counted
  `ASSERT_SAME(a_uninit, clk, rst, out_valid && reason_code == rrq_pkg::RC_UNINIT,
    request && enter_count == 16'd0 && exit_count == 16'd0 && degraded_count == 16'd0)

  // Missing inputs report the degraded count alone
  `ASSERT_SAME(a_missing, clk, rst,
    out_valid && (reason_code == rrq_pkg::RC_MISSING ||
                  reason_code == rrq_pkg::RC_MISSING_PENDING),
    enter_count == 16'd0 && exit_count == 16'd0 && degraded_count != 16'd0)

  // Request cleared or still building up shows the flag low
  `ASSERT_SAME(a_low_request, clk, rst,
    out_valid && (reason_code == rrq_pkg::RC_OK ||
                  reason_code == rrq_pkg::RC_HIGH_PENDING),
    !request && degraded_count == 16'd0)

endmodule

bind relocalization_request_qualifier_unit rrq_checker u_rrq_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .request        (request),
  .reason_code    (reason_code),
  .enter_count    (enter_count),
  .exit_count     (exit_count),
  .degraded_count (degraded_count)
);

### bench/relocalization_request_qualifier_unit_test.sv
// ----------------------------------------------------------------------------
// relocalization_request_qualifier_unit_test
// Self-checking bench for the relocalization request qualifier. A clocked
// driver feeds sample words from a queue and a clocked monitor checks every
// result word against a cycle-free predictor of the hysteresis detector. It
// runs a directed opening, random phases over several register settings with
// random idling on both sides, long receiver hold-offs and a long outage run.
// ----------------------------------------------------------------------------
module relocalization_request_qualifier_unit_test;

  localparam int unsigned CNT_W = 16;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam int LATENCY = 2;
  localparam int HOLD_OFF_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_we = 1'b0;
  logic [rrq_pkg::CFG_IDX_W-1:0]  cfg_index = rrq_pkg::CFG_ENTER_THRESHOLD;
  logic [rrq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               initialized = 1'b0;
  logic               sources_ready = 1'b0;
  logic               residual_finite = 1'b0;
  logic signed [31:0] residual = '0;
  logic [15:0]        reject_streak = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        request;
  logic [3:0]  reason_code;
  logic [15:0] enter_count;
  logic [15:0] exit_count;
  logic [15:0] degraded_count;

  relocalization_request_qualifier_unit #(
    .COUNT_WIDTH(CNT_W)
  ) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .initialized(initialized), .sources_ready(sources_ready),
    .residual_finite(residual_finite), .residual(residual),
    .reject_streak(reject_streak),
    .out_valid(out_valid), .out_stall(out_stall),
    .request(request), .reason_code(reason_code),
    .enter_count(enter_count), .exit_count(exit_count),
    .degraded_count(degraded_count)
  );

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Word stores and bookkeeping
  rrq_pkg::rrq_item_t   pending_samples[$];
  rrq_pkg::rrq_result_t expected_results[$];
  int samples_queued = 0;
  int results_seen = 0;
  int fail_count = 0;
  int settings_used = 0;
  int reason_hits[16];
  bit in_taken = 1'b0;
  bit no_idle = 1'b0;
  int holds_wanted = 0;
  int holds_done = 0;
  int hold_left = 0;

  // Predictor state and register copy
  rrq_pkg::rrq_cfg_t reg_copy = '{rrq_pkg::ENTER_THRESHOLD_RST, rrq_pkg::EXIT_THRESHOLD_RST,
                                  rrq_pkg::ENTER_HOLD_RST, rrq_pkg::EXIT_HOLD_RST,
                                  rrq_pkg::REJECT_LIMIT_RST};
  bit              req_state = 1'b1;
  longint unsigned enter_cnt = 0;
  longint unsigned exit_cnt = 0;
  longint unsigned degraded_cnt = 0;

  // Random stream shaping
  bit trend_up = 1'b0;
  int outage_left = 0;

  function automatic longint unsigned sat_inc(input longint unsigned v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 1;
  endfunction

  function automatic longint unsigned sat_load(input longint unsigned v);
    return (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  function automatic logic [15:0] clip_report(input longint unsigned v);
    return (v > rrq_pkg::REPORT_MAX) ? rrq_pkg::REPORT_MAX : v[15:0];
  endfunction

  // Advance the detector by one sample and return its result word
  function automatic rrq_pkg::rrq_result_t qualify_sample(input rrq_pkg::rrq_item_t s);
    rrq_pkg::rrq_result_t r;
    rrq_pkg::rrq_reason_t why;
    longint unsigned      ec, xc, dc;
    ec = 0;
    xc = 0;
    dc = 0;
    if (!s.initialized) begin
      req_state = 1'b1;
      enter_cnt = 0;
      exit_cnt = 0;
      degraded_cnt = 0;
      why = rrq_pkg::RC_UNINIT;
    end else if (!s.sources_ready) begin
      degraded_cnt = sat_inc(degraded_cnt);
      enter_cnt = 0;
      exit_cnt = 0;
      if (degraded_cnt >= reg_copy.enter_hold) begin
        req_state = 1'b1;
        why = rrq_pkg::RC_MISSING;
      end else begin
        why = rrq_pkg::RC_MISSING_PENDING;
      end
      dc = degraded_cnt;
    end else begin
      degraded_cnt = 0;
      if (!s.residual_finite) begin
        req_state = 1'b1;
        enter_cnt = 0;
        exit_cnt = 0;
        why = rrq_pkg::RC_INVALID;
      end else if (s.reject_streak >= reg_copy.reject_limit) begin
        req_state = 1'b1;
        enter_cnt = sat_load(reg_copy.enter_hold);
        exit_cnt = 0;
        why = rrq_pkg::RC_REJECTS;
        ec = enter_cnt;
      end else begin
        if (req_state) begin
          if ($signed(s.residual) < $signed(reg_copy.exit_threshold)) begin
            exit_cnt = sat_inc(exit_cnt);
            if (exit_cnt >= reg_copy.exit_hold) begin
              req_state = 1'b0;
              enter_cnt = 0;
              exit_cnt = 0;
              why = rrq_pkg::RC_OK;
            end else begin
              why = rrq_pkg::RC_RECOVERING;
            end
          end else begin
            exit_cnt = 0;
            why = rrq_pkg::RC_HIGH;
          end
        end else begin
          if ($signed(s.residual) > $signed(reg_copy.enter_threshold)) begin
            enter_cnt = sat_inc(enter_cnt);
            if (enter_cnt >= reg_copy.enter_hold) begin
              req_state = 1'b1;
              enter_cnt = sat_load(reg_copy.enter_hold);
              exit_cnt = 0;
              why = rrq_pkg::RC_HIGH;
            end else begin
              why = rrq_pkg::RC_HIGH_PENDING;
            end
          end else begin
            enter_cnt = 0;
            why = rrq_pkg::RC_OK;
          end
        end
        ec = enter_cnt;
        xc = exit_cnt;
        dc = degraded_cnt;
      end
    end
    r.request = req_state;
    r.reason_code = why;
    r.enter_count = clip_report(ec);
    r.exit_count = clip_report(xc);
    r.degraded_count = clip_report(dc);
    return r;
  endfunction

  function automatic rrq_pkg::rrq_item_t make_sample(input bit init, input bit ready,
                                                     input bit fin, input logic [31:0] res,
                                                     input logic [15:0] rej);
    rrq_pkg::rrq_item_t s;
    s.initialized = init;
    s.sources_ready = ready;
    s.residual_finite = fin;
    s.residual = res;
    s.reject_streak = rej;
    return s;
  endfunction

  // Offset from a threshold, clamped to the Q16.16 range
  function automatic logic [31:0] near_threshold(input logic signed [31:0] thr, input bit above);
    longint v;
    v = longint'(thr) + (above ? 1 : -1) * longint'($urandom_range(1, 3 * 65536));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Mostly well-formed runs around the thresholds, with outages and noise
  function automatic rrq_pkg::rrq_item_t random_sample();
    rrq_pkg::rrq_item_t s;
    int pick;
    logic [15:0] below_limit;
    pick = $urandom_range(0, 99);
    s = make_sample(1'b1, 1'b1, 1'b1, $urandom, 16'($urandom_range(0, 65535)));
    if (reg_copy.reject_limit == 0) begin
      below_limit = 16'($urandom_range(0, 65535));
    end else begin
      below_limit = 16'($urandom_range(0, reg_copy.reject_limit - 1));
    end
    if (outage_left > 0) begin
      outage_left--;
      s.sources_ready = 1'b0;
    end else if (pick < 3) begin
      s.initialized = 1'b0;
      s.sources_ready = 1'($urandom_range(0, 1));
      s.residual_finite = 1'($urandom_range(0, 1));
    end else if (pick < 7) begin
      outage_left = $urandom_range(0, 5);
      s.sources_ready = 1'b0;
      s.residual_finite = 1'($urandom_range(0, 1));
    end else if (pick < 11) begin
      s.residual_finite = 1'b0;
    end else if (pick < 16) begin
      s.reject_streak = 16'($urandom_range(reg_copy.reject_limit, 65535));
    end else begin
      s.reject_streak = below_limit;
      if ($urandom_range(0, 7) == 0) trend_up = !trend_up;
      if (pick < 24) begin
        s.residual = $urandom;
      end else if (pick < 29) begin
        s.residual = trend_up ? reg_copy.enter_threshold : reg_copy.exit_threshold;
      end else if (trend_up) begin
        s.residual = near_threshold(reg_copy.enter_threshold, 1'b1);
      end else begin
        s.residual = near_threshold(reg_copy.exit_threshold, 1'b0);
      end
    end
    return s;
  endfunction

  // Driver: present the next word at the falling edge, hold while stalled
  always @(negedge clk) begin
    rrq_pkg::rrq_item_t nxt;
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_samples.size() > 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
        nxt = pending_samples.pop_front();
        initialized <= nxt.initialized;
        sources_ready <= nxt.sources_ready;
        residual_finite <= nxt.residual_finite;
        residual <= nxt.residual;
        reject_streak <= nxt.reject_streak;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < holds_wanted) begin
      holds_done++;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 30);
    end
  end

  // Monitor: predict on accepted samples, check accepted results
  always @(posedge clk) begin
    rrq_pkg::rrq_item_t   got;
    rrq_pkg::rrq_result_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        got = make_sample(initialized, sources_ready, residual_finite, residual,
                          reject_streak);
        expected_results.push_back(qualify_sample(got));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no sample outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          results_seen++;
          reason_hits[reason_code]++;
          if (request !== want.request) begin
            $error("request: expected %0d, got %0d", want.request, request);
            fail_count++;
          end
          if (reason_code !== want.reason_code) begin
            $error("reason_code: expected %0d, got %0d", want.reason_code, reason_code);
            fail_count++;
          end
          if (enter_count !== want.enter_count) begin
            $error("enter_count: expected %0d, got %0d", want.enter_count, enter_count);
            fail_count++;
          end
          if (exit_count !== want.exit_count) begin
            $error("exit_count: expected %0d, got %0d", want.exit_count, exit_count);
            fail_count++;
          end
          if (degraded_count !== want.degraded_count) begin
            $error("degraded_count: expected %0d, got %0d", want.degraded_count,
                   degraded_count);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic offer(input rrq_pkg::rrq_item_t s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // Wait until every queued sample has come back, then let the pipe settle
  task automatic drain();
    while (pending_samples.size() != 0 || results_seen < samples_queued) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rrq_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input rrq_pkg::rrq_cfg_t c);
    write_reg(rrq_pkg::CFG_ENTER_THRESHOLD, c.enter_threshold);
    write_reg(rrq_pkg::CFG_EXIT_THRESHOLD, c.exit_threshold);
    write_reg(rrq_pkg::CFG_ENTER_HOLD, {16'd0, c.enter_hold});
    write_reg(rrq_pkg::CFG_EXIT_HOLD, {16'd0, c.exit_hold});
    write_reg(rrq_pkg::CFG_REJECT_LIMIT, {16'd0, c.reject_limit});
    reg_copy = c;
    settings_used++;
  endtask

  task automatic offer_random(input int n);
    for (int i = 0; i < n; i++) offer(random_sample());
  endtask

  // Stimulus
  initial begin
    rrq_pkg::rrq_cfg_t c;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening on reset settings: overrides, then both hysteresis edges
    offer(make_sample(1'b0, 1'b1, 1'b0, 32'h8000_0000, 16'hFFFF));
    repeat (3) offer(make_sample(1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF, 16'hFFFF));
    offer(make_sample(1'b1, 1'b1, 1'b0, 32'h7FFF_FFFF, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd0, 16'd10));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'h8000_0000, 16'hFFFF));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd32768, 16'd9));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd32767, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd0, 16'd5));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'h8000_0000, 16'd9));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd32767, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd65536, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd65537, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'h7FFF_FFFF, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd65537, 16'd0));
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'h8000_0000, 16'd0));
    offer(make_sample(1'b0, 1'b0, 1'b1, 32'd0, 16'd0));
    drain();

    // Reset settings again, first stretch with no idling on either side
    c = '{32'sd65536, 32'sd32768, 16'd3, 16'd5, 16'd10};
    apply_settings(c);
    no_idle = 1'b1;
    offer_random(120);
    drain();
    no_idle = 1'b0;
    offer_random(230);
    drain();

    // All zero: holds met at once, every clean sample counts as rejects
    apply_settings('{32'sd0, 32'sd0, 16'd0, 16'd0, 16'd0});
    offer_random(100);
    drain();

    // Thresholds at the range ends, holds and limit at their maximum
    apply_settings('{32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    offer_random(150);
    drain();

    // Negative thresholds, short holds; receiver holds off while words pile up
    apply_settings('{-32'sd131072, -32'sd196608, 16'd1, 16'd2, 16'd300});
    offer_random(300);
    holds_wanted++;
    drain();

    // Overlapping band with the enter threshold under the exit threshold
    apply_settings('{-32'sd32768, 32'sd98304, 16'd4, 16'd7, 16'd1000});
    offer_random(150);
    holds_wanted++;
    offer_random(150);
    drain();

    // Long outage under the largest hold keeps the missing report pending, then recover
    apply_settings('{32'sd65536, 32'sd32768, 16'hFFFF, 16'd5, 16'd10});
    no_idle = 1'b1;
    for (int i = 0; i < 30; i++) begin
      offer(make_sample(1'b1, 1'b0, 1'b1, $urandom, 16'($urandom_range(0, 65535))));
    end
    offer(make_sample(1'b1, 1'b1, 1'b1, 32'd0, 16'd0));
    drain();
    no_idle = 1'b0;

    repeat (LATENCY + 8) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      fail_count++;
    end
    $display("Covered %0d sample words over %0d register settings, %0d results checked",
             samples_queued, settings_used, results_seen);
    $display("Reasons seen: uninit %0d missing %0d pending %0d invalid %0d rejects %0d",
             reason_hits[rrq_pkg::RC_UNINIT], reason_hits[rrq_pkg::RC_MISSING],
             reason_hits[rrq_pkg::RC_MISSING_PENDING], reason_hits[rrq_pkg::RC_INVALID],
             reason_hits[rrq_pkg::RC_REJECTS]);
    $display("  ok %0d recovering %0d high %0d high pending %0d",
             reason_hits[rrq_pkg::RC_OK], reason_hits[rrq_pkg::RC_RECOVERING],
             reason_hits[rrq_pkg::RC_HIGH], reason_hits[rrq_pkg::RC_HIGH_PENDING]);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000;
    $display("Timeout: %0d of %0d results seen", results_seen, samples_queued);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/rrq_pkg.sv
hdl/rrq_cfg_regs.sv
hdl/rrq_core.sv
hdl/relocalization_request_qualifier_unit.sv
hdl/rrq_checker.sv
bench/relocalization_request_qualifier_unit_test.sv
